### hw/rtl/wat_pkg.sv
// Shared constants and types for the windowed average threshold alarm.
package wat_pkg;

    localparam int LIMIT_W     = 10;
    localparam int COUNT_OUT_W = 5;
    localparam int AVG_OUT_W   = 10;
    localparam int CFG_IDX_W   = 2;

    localparam logic [LIMIT_W-1:0] HUM_LIMIT_RST  = 10'd950;
    localparam logic [LIMIT_W-1:0] DUST_LIMIT_RST = 10'd920;

    localparam logic [CFG_IDX_W-1:0] REG_HUMIDITY_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DUST_LIMIT     = 2'd1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

### hw/rtl/wat_front.sv
// Front end: accepts sample words and holds them in a two-entry queue.
module wat_front import wat_pkg::*; #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [SAMPLE_BITS-1:0] i_humidity_sample,
    input  logic [SAMPLE_BITS-1:0] i_dust_sample,
    output logic                   o_q_valid,
    input  logic                   i_q_ready,
    output logic [SAMPLE_BITS-1:0] o_q_hum,
    output logic [SAMPLE_BITS-1:0] o_q_dust
);

    logic [SAMPLE_BITS-1:0] r_hum [2];
    logic [SAMPLE_BITS-1:0] r_dust [2];
    logic                   r_wr_ptr;
    logic                   r_rd_ptr;
    logic [1:0]             r_cnt;
    logic                   push;
    logic                   pop;

    assign o_in_ready = (r_cnt != 2'd2);
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_hum    = r_hum[r_rd_ptr];
    assign o_q_dust   = r_dust[r_rd_ptr];
    assign push       = i_in_valid & o_in_ready;
    assign pop        = o_q_valid & i_q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (push) begin
                r_hum[r_wr_ptr]  <= i_humidity_sample;
                r_dust[r_wr_ptr] <= i_dust_sample;
                r_wr_ptr         <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

### hw/rtl/wat_div.sv
// Restoring divider, one quotient bit per cycle.
module wat_div import wat_pkg::*; #(
    parameter int DW = 15,
    parameter int VW = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic [DW-1:0] o_quot,
    output t_div_stat     o_stat
);

    localparam int CTW = $clog2(DW + 1);

    logic [DW-1:0]  r_quot;
    logic [VW-1:0]  r_rem;
    logic [VW-1:0]  r_divisor;
    logic [CTW-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [VW:0]    trial;
    logic           fits;

    // shift in the next dividend bit and try the subtraction
    assign trial = {r_rem, r_quot[DW-1]};
    assign fits  = (trial >= {1'b0, r_divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quot    <= i_dividend;
                r_rem     <= '0;
                r_divisor <= i_divisor;
                r_cnt     <= CTW'(DW);
                r_busy    <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= fits ? VW'(trial - {1'b0, r_divisor}) : VW'(trial);
                r_quot <= {r_quot[DW-2:0], fits};
                r_cnt  <= r_cnt - CTW'(1);
                if (r_cnt == CTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot      = r_quot;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

### hw/rtl/wat_back.sv
// Back end: sample ring, running sums, averaging and the result register.
module wat_back import wat_pkg::*; #(
    parameter int WINDOW      = 20,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    output logic                   o_q_ready,
    input  logic [SAMPLE_BITS-1:0] i_q_hum,
    input  logic [SAMPLE_BITS-1:0] i_q_dust,
    input  logic [LIMIT_W-1:0]     i_hum_limit,
    input  logic [LIMIT_W-1:0]     i_dust_limit,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [COUNT_OUT_W-1:0] o_samples_in_window,
    output logic [AVG_OUT_W-1:0]   o_humidity_average,
    output logic [AVG_OUT_W-1:0]   o_dust_average,
    output logic                   o_humidity_warning,
    output logic                   o_dust_warning
);

    localparam int CNTW = $clog2(WINDOW + 1);
    localparam int PW   = $clog2(WINDOW);
    localparam int SW   = SAMPLE_BITS + CNTW;
    localparam int MW   = 2 * SAMPLE_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_DIVIDE,
        S_RESULT
    } t_state;

    t_state                 r_state;
    logic [CNTW-1:0]        r_fill;
    logic [PW-1:0]          r_pos;
    logic [SW-1:0]          r_hum_sum;
    logic [SW-1:0]          r_dust_sum;
    logic [SAMPLE_BITS-1:0] r_hum;
    logic [SAMPLE_BITS-1:0] r_dust;
    logic [MW-1:0]          r_rd_data;
    logic [MW-1:0]          r_ring [WINDOW];

    logic                   r_out_valid;
    logic [COUNT_OUT_W-1:0] r_out_cnt;
    logic [AVG_OUT_W-1:0]   r_out_hum;
    logic [AVG_OUT_W-1:0]   r_out_dust;
    logic                   r_out_hum_warn;
    logic                   r_out_dust_warn;

    logic                   full;
    logic [CNTW-1:0]        n_fill;
    logic [PW-1:0]          n_pos;
    logic [SW-1:0]          n_hum_sum;
    logic [SW-1:0]          n_dust_sum;
    logic [SAMPLE_BITS-1:0] old_hum;
    logic [SAMPLE_BITS-1:0] old_dust;
    logic                   div_start;
    logic                   ring_we;
    logic [SW-1:0]          hum_quot;
    logic [SW-1:0]          dust_quot;
    t_div_stat              hum_stat;
    t_div_stat              dust_stat;

    assign full     = (r_fill == CNTW'(WINDOW));
    assign old_hum  = r_rd_data[MW-1:SAMPLE_BITS];
    assign old_dust = r_rd_data[SAMPLE_BITS-1:0];

    // drop the oldest pair only once the ring has wrapped
    always_comb begin
        n_hum_sum  = r_hum_sum + SW'(r_hum);
        n_dust_sum = r_dust_sum + SW'(r_dust);
        n_fill     = r_fill + CNTW'(1);
        if (full) begin
            n_hum_sum  = n_hum_sum - SW'(old_hum);
            n_dust_sum = n_dust_sum - SW'(old_dust);
            n_fill     = r_fill;
        end
        n_pos = (r_pos == PW'(WINDOW - 1)) ? '0 : r_pos + PW'(1);
    end

    assign ring_we   = (r_state == S_LOOKUP);
    assign div_start = (r_state == S_LOOKUP);
    assign o_q_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[r_pos] <= {r_hum, r_dust};
        end
        r_rd_data <= r_ring[r_pos];
    end

    wat_div #(.DW(SW), .VW(CNTW)) u_hum_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_hum_sum),
        .i_divisor  (n_fill),
        .o_quot     (hum_quot),
        .o_stat     (hum_stat)
    );

    wat_div #(.DW(SW), .VW(CNTW)) u_dust_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_dust_sum),
        .i_divisor  (n_fill),
        .o_quot     (dust_quot),
        .o_stat     (dust_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_pos       <= '0;
            r_hum_sum   <= '0;
            r_dust_sum  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drop a taken result unless a new one replaces it this cycle
            if (r_out_valid && i_out_ready && (r_state != S_RESULT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_hum   <= i_q_hum;
                        r_dust  <= i_q_dust;
                        r_state <= S_LOOKUP;
                    end
                end
                S_LOOKUP: begin
                    r_hum_sum  <= n_hum_sum;
                    r_dust_sum <= n_dust_sum;
                    r_fill     <= n_fill;
                    r_pos      <= n_pos;
                    r_state    <= S_DIVIDE;
                end
                S_DIVIDE: begin
                    if (hum_stat.done && dust_stat.done) begin
                        r_state <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    // hold until the result register is free or being emptied
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid     <= 1'b1;
                        r_out_cnt       <= COUNT_OUT_W'(r_fill);
                        r_out_hum       <= AVG_OUT_W'(hum_quot);
                        r_out_dust      <= AVG_OUT_W'(dust_quot);
                        r_out_hum_warn  <= (hum_quot >= SW'(i_hum_limit));
                        r_out_dust_warn <= (dust_quot >= SW'(i_dust_limit));
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_samples_in_window = r_out_cnt;
    assign o_humidity_average  = r_out_hum;
    assign o_dust_average      = r_out_dust;
    assign o_humidity_warning  = r_out_hum_warn;
    assign o_dust_warning      = r_out_dust_warn;

    a_fill_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNTW'(WINDOW))
        else $error("fill count beyond window");

    a_pos_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_pos} < (PW+1)'(WINDOW))
        else $error("write position beyond window");

    a_div_lockstep : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hum_stat == dust_stat)
        else $error("dividers out of step");

    a_fill_on_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT) |-> (r_fill != '0))
        else $error("result with empty window");

endmodule

### hw/rtl/windowed_average_threshold_alarm.sv
// Top level of the windowed average threshold alarm.
// Each accepted word carries one humidity and one dust sample. The block keeps the last
// WINDOW pairs in a ring, maintains running sums and a fill count, and for every word
// returns the number of stored pairs, the truncated average of each channel and a
// warning flag per channel that is set when the average reaches its limit register.
// A two-entry queue at the input lets the sender keep going while the back end works;
// the back end handles one word at a time and forms the two averages with a pair of
// bit-serial dividers, one quotient bit a cycle. A finished result sits in an output
// register, so the next word starts while the previous result waits to be taken. The
// limits are written through a simple write port (index 0 humidity limit, index 1 dust
// limit, other indexes ignored) and must only change while the block is idle; they
// reset to 950 and 920.
module windowed_average_threshold_alarm import wat_pkg::*; #(
    parameter int WINDOW      = 20,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [LIMIT_W-1:0]     i_cfg_wdata,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [SAMPLE_BITS-1:0] i_humidity_sample,
    input  logic [SAMPLE_BITS-1:0] i_dust_sample,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [COUNT_OUT_W-1:0] o_samples_in_window,
    output logic [AVG_OUT_W-1:0]   o_humidity_average,
    output logic [AVG_OUT_W-1:0]   o_dust_average,
    output logic                   o_humidity_warning,
    output logic                   o_dust_warning
);

    logic [LIMIT_W-1:0]     r_hum_limit;
    logic [LIMIT_W-1:0]     r_dust_limit;
    logic                   q_valid;
    logic                   q_ready;
    logic [SAMPLE_BITS-1:0] q_hum;
    logic [SAMPLE_BITS-1:0] q_dust;

    // Limit registers; writes to unused indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hum_limit  <= HUM_LIMIT_RST;
            r_dust_limit <= DUST_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_HUMIDITY_LIMIT: r_hum_limit  <= i_cfg_wdata;
                REG_DUST_LIMIT:     r_dust_limit <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Front end: accept words and queue them.
    wat_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_humidity_sample (i_humidity_sample),
        .i_dust_sample     (i_dust_sample),
        .o_q_valid         (q_valid),
        .i_q_ready         (q_ready),
        .o_q_hum           (q_hum),
        .o_q_dust          (q_dust)
    );

    // Back end: update the window, divide, compare and register the result.
    wat_back #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_q_valid           (q_valid),
        .o_q_ready           (q_ready),
        .i_q_hum             (q_hum),
        .i_q_dust            (q_dust),
        .i_hum_limit         (r_hum_limit),
        .i_dust_limit        (r_dust_limit),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_samples_in_window (o_samples_in_window),
        .o_humidity_average  (o_humidity_average),
        .o_dust_average      (o_dust_average),
        .o_humidity_warning  (o_humidity_warning),
        .o_dust_warning      (o_dust_warning)
    );

endmodule

### verif/windowed_average_threshold_alarm_tb.sv
// Self-checking testbench for the windowed average threshold alarm.
`timescale 1ns / 100ps

module windowed_average_threshold_alarm_tb import wat_pkg::*;;

    localparam int SAMPLE_W      = 10;
    localparam int WINDOW_DEPTH  = 20;
    localparam int SETTLE_CYCLES = 40;   // idle wait after a drain, before limit writes and at the end
    localparam int SEED_ROWS     = 25;
    localparam int REPORT_MAX    = 10;

    // Indexes that the block must ignore
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef enum int {
        SMP_UNIFORM,
        SMP_EXTREME,
        SMP_TOP,
        SMP_FLAT
    } t_sample_mix;

    typedef struct packed {
        logic [COUNT_OUT_W-1:0] count;
        logic [AVG_OUT_W-1:0]   hum_avg;
        logic [AVG_OUT_W-1:0]   dust_avg;
        logic                   hum_warn;
        logic                   dust_warn;
    } t_window_result;

    typedef struct packed {
        logic [SAMPLE_W-1:0] hum;
        logic [SAMPLE_W-1:0] dust;
        logic                typed;
        t_window_result      res;
    } t_seed_row;

    // ------------------------------------------------------------------
    // Block I/O
    // ------------------------------------------------------------------
    logic                   i_clk               = 1'b0;
    logic                   i_rst_n             = 1'b0;
    logic                   i_cfg_we            = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx           = REG_HUMIDITY_LIMIT;
    logic [LIMIT_W-1:0]     i_cfg_wdata         = '0;
    logic                   i_in_valid          = 1'b0;
    logic                   o_in_ready;
    logic [SAMPLE_W-1:0]    i_humidity_sample   = '0;
    logic [SAMPLE_W-1:0]    i_dust_sample       = '0;
    logic                   o_out_valid;
    logic                   i_out_ready         = 1'b0;
    logic [COUNT_OUT_W-1:0] o_samples_in_window;
    logic [AVG_OUT_W-1:0]   o_humidity_average;
    logic [AVG_OUT_W-1:0]   o_dust_average;
    logic                   o_humidity_warning;
    logic                   o_dust_warning;

    windowed_average_threshold_alarm #(
        .WINDOW      (WINDOW_DEPTH),
        .SAMPLE_BITS (SAMPLE_W)
    ) u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_humidity_sample   (i_humidity_sample),
        .i_dust_sample       (i_dust_sample),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_samples_in_window (o_samples_in_window),
        .o_humidity_average  (o_humidity_average),
        .o_dust_average      (o_dust_average),
        .o_humidity_warning  (o_humidity_warning),
        .o_dust_warning      (o_dust_warning)
    );

    // 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Window predictor: own copy of the rings, sums, count and limits
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] win_hum_ring  [WINDOW_DEPTH];
    logic [SAMPLE_W-1:0] win_dust_ring [WINDOW_DEPTH];
    logic [4:0]          win_pos;
    logic [4:0]          win_fill;
    logic [14:0]         win_hum_sum;
    logic [14:0]         win_dust_sum;
    logic [LIMIT_W-1:0]  hum_limit_now;
    logic [LIMIT_W-1:0]  dust_limit_now;

    t_window_result pending_averages [$];
    int             fault_count = 0;

    // Directed opening: extremes, alternating bit patterns, values around the
    // reset limits, then enough words to fill the ring and start evicting.
    // Only the first two rows carry a hand-worked result (reset limits 950/920).
    t_seed_row seed_rows [SEED_ROWS] = '{
        '{10'd1023, 10'd1023, 1'b1, '{5'd1, 10'd1023, 10'd1023, 1'b1, 1'b1}},
        '{10'd0,    10'd0,    1'b1, '{5'd2, 10'd511,  10'd511,  1'b0, 1'b0}},
        '{10'd1023, 10'd0,    1'b0, '0},
        '{10'd0,    10'd1023, 1'b0, '0},
        '{10'h155,  10'h2AA,  1'b0, '0},
        '{10'h2AA,  10'h155,  1'b0, '0},
        '{10'd1,    10'd512,  1'b0, '0},
        '{10'd512,  10'd1,    1'b0, '0},
        '{10'd1023, 10'd1023, 1'b0, '0},
        '{10'd1023, 10'd1023, 1'b0, '0},
        '{10'd1022, 10'd1021, 1'b0, '0},
        '{10'd950,  10'd920,  1'b0, '0},
        '{10'd949,  10'd919,  1'b0, '0},
        '{10'h0F0,  10'h30F,  1'b0, '0},
        '{10'h30F,  10'h0F0,  1'b0, '0},
        '{10'd0,    10'd0,    1'b0, '0},
        '{10'd1023, 10'd1023, 1'b0, '0},
        '{10'd1,    10'd1,    1'b0, '0},
        '{10'd1023, 10'd1023, 1'b0, '0},
        '{10'd1023, 10'd1023, 1'b0, '0},
        '{10'd0,    10'd1023, 1'b0, '0},
        '{10'd1023, 10'd0,    1'b0, '0},
        '{10'd500,  10'd600,  1'b0, '0},
        '{10'd1023, 10'd1023, 1'b0, '0},
        '{10'd1023, 10'd1023, 1'b0, '0}
    };

    // Clear the predictor to its post-reset state
    task automatic clear_window();
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            win_hum_ring[i]  = '0;
            win_dust_ring[i] = '0;
        end
        win_pos        = '0;
        win_fill       = '0;
        win_hum_sum    = '0;
        win_dust_sum   = '0;
        hum_limit_now  = HUM_LIMIT_RST;
        dust_limit_now = DUST_LIMIT_RST;
    endtask

    // Push one sample pair into the window and work out the averages and flags
    function automatic t_window_result advance_window(input logic [SAMPLE_W-1:0] hum,
                                                      input logic [SAMPLE_W-1:0] dust);
        t_window_result res;
        logic [14:0]    hum_q;
        logic [14:0]    dust_q;
        // Full ring: drop the oldest pair from the sums before it is overwritten
        if (win_fill >= WINDOW_DEPTH) begin
            win_hum_sum  = win_hum_sum - win_hum_ring[win_pos];
            win_dust_sum = win_dust_sum - win_dust_ring[win_pos];
        end else begin
            win_fill = win_fill + 5'd1;
        end
        win_hum_ring[win_pos]  = hum;
        win_dust_ring[win_pos] = dust;
        win_hum_sum  = win_hum_sum + hum;
        win_dust_sum = win_dust_sum + dust;
        win_pos = (win_pos == WINDOW_DEPTH - 1) ? 5'd0 : win_pos + 5'd1;

        hum_q  = win_hum_sum / win_fill;
        dust_q = win_dust_sum / win_fill;
        res.count     = win_fill;
        res.hum_avg   = hum_q[AVG_OUT_W-1:0];
        res.dust_avg  = dust_q[AVG_OUT_W-1:0];
        res.hum_warn  = (hum_q >= hum_limit_now);
        res.dust_warn = (dust_q >= dust_limit_now);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Pacing helpers
    // ------------------------------------------------------------------
    // Mostly no gap, some short ones, the odd long one
    function automatic int pick_gap(input bit steady);
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample(input t_sample_mix mix,
                                                        input int centre);
        int roll;
        roll = $urandom_range(0, 99);
        case (mix)
            SMP_EXTREME: begin
                case (roll % 4)
                    0:       return '0;
                    1:       return 10'd1;
                    2:       return 10'd1022;
                    default: return '1;
                endcase
            end
            SMP_TOP: begin
                // Mostly full scale so that whole windows of 1023 turn up
                return (roll < 95) ? 10'd1023 : 10'($urandom_range(0, 1023));
            end
            SMP_FLAT: begin
                return 10'($urandom_range(centre - 1, centre + 1));
            end
            default: begin
                if (roll < 8)  return '0;
                if (roll < 16) return '1;
                return 10'($urandom_range(0, 1023));
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checker: compare every accepted result with the oldest one due
    // ------------------------------------------------------------------
    task automatic note_fault(input string what);
        fault_count++;
        if (fault_count <= REPORT_MAX)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    always @(posedge i_clk) begin : result_check
        t_window_result got;
        t_window_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_samples_in_window, o_humidity_average, o_dust_average,
                    o_humidity_warning, o_dust_warning};
            if (pending_averages.size() == 0) begin
                note_fault($sformatf("unexpected result cnt=%0d hum=%0d dust=%0d hw=%0b dw=%0b",
                                     got.count, got.hum_avg, got.dust_avg,
                                     got.hum_warn, got.dust_warn));
            end else begin
                want = pending_averages.pop_front();
                if (got !== want)
                    note_fault($sformatf({"exp cnt=%0d hum=%0d dust=%0d hw=%0b dw=%0b, ",
                                          "got cnt=%0d hum=%0d dust=%0d hw=%0b dw=%0b"},
                                         want.count, want.hum_avg, want.dust_avg,
                                         want.hum_warn, want.dust_warn,
                                         got.count, got.hum_avg, got.dust_avg,
                                         got.hum_warn, got.dust_warn));
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: ready with random stalls and occasional long free runs
    // ------------------------------------------------------------------
    initial begin : sink_pacing
        int run_len;
        int stall_len;
        @(negedge i_clk);
        forever begin
            i_out_ready <= 1'b1;
            run_len = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 150)
                                                   : $urandom_range(1, 6);
            repeat (run_len) @(negedge i_clk);
            stall_len = pick_gap(1'b0);
            if (stall_len > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall_len) @(negedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sample side
    // ------------------------------------------------------------------
    // Offer one word and hold it until taken. Called and returns at a falling
    // edge; valid is left high so that back-to-back words need no toggle.
    task automatic send_pair(input logic [SAMPLE_W-1:0] hum,
                             input logic [SAMPLE_W-1:0] dust,
                             input bit steady,
                             input bit typed,
                             input t_window_result typed_res);
        int             gap;
        t_window_result predicted;
        gap = pick_gap(steady);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_humidity_sample <= hum;
        i_dust_sample     <= dust;
        i_in_valid        <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = advance_window(hum, dust);
        pending_averages.push_back(typed ? typed_res : predicted);
        @(negedge i_clk);
    endtask

    // Drop valid and hold off until every result due has come back
    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        while (pending_averages.size() != 0) @(negedge i_clk);
    endtask

    // Write both limits, then the two unused indexes with junk, one per cycle.
    // Only called with the block idle.
    task automatic write_limits(input logic [LIMIT_W-1:0] hum_lim,
                                input logic [LIMIT_W-1:0] dust_lim);
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= REG_HUMIDITY_LIMIT;
        i_cfg_wdata <= hum_lim;
        @(negedge i_clk);
        i_cfg_idx   <= REG_DUST_LIMIT;
        i_cfg_wdata <= dust_lim;
        @(negedge i_clk);
        i_cfg_idx   <= REG_SPARE_2;
        i_cfg_wdata <= LIMIT_W'($urandom_range(0, 1023));
        @(negedge i_clk);
        i_cfg_idx   <= REG_SPARE_3;
        i_cfg_wdata <= LIMIT_W'($urandom_range(0, 1023));
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        hum_limit_now  = hum_lim;
        dust_limit_now = dust_lim;
        @(negedge i_clk);
    endtask

    // Random burst of sample pairs; optionally pause for a full drain part way
    task automatic random_burst(input int words, input t_sample_mix mix,
                                input int hum_centre, input int dust_centre,
                                input bit steady, input int pause_at);
        for (int n = 0; n < words; n++) begin
            if (n == pause_at) hold_until_drained();
            send_pair(pick_sample(mix, hum_centre), pick_sample(mix, dust_centre),
                      steady, 1'b0, '0);
        end
    endtask

    initial begin : stimulus
        int hum_c;
        int dust_c;
        clear_window();
        // Hold reset, then release it on a falling edge
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed opening at the reset limits
        for (int r = 0; r < SEED_ROWS; r++)
            send_pair(seed_rows[r].hum, seed_rows[r].dust, 1'b0,
                      seed_rows[r].typed, seed_rows[r].res);

        // Lowest limits: every average raises both warnings
        write_limits('0, '0);
        random_burst(100, SMP_UNIFORM, 0, 0, 1'b0, -1);

        // Highest limits: only a window of full-scale samples warns; extremes back to back
        write_limits('1, '1);
        random_burst(40, SMP_EXTREME, 0, 0, 1'b1, -1);
        random_burst(60, SMP_TOP, 0, 0, 1'b0, -1);

        // Mid-range limits with a drain part way through
        write_limits(LIMIT_W'($urandom_range(400, 620)), LIMIT_W'($urandom_range(400, 620)));
        random_burst(150, SMP_UNIFORM, 0, 0, 1'b0, 75);

        // Flat signals sitting on the limit, so the flags flip on truncation
        for (int k = 0; k < 4; k++) begin
            hum_c  = $urandom_range(1, 1022);
            dust_c = $urandom_range(1, 1022);
            write_limits(LIMIT_W'(hum_c), LIMIT_W'(dust_c));
            random_burst(50, SMP_FLAT, hum_c, dust_c, (k == 2), -1);
        end

        // Fully random limits
        write_limits(LIMIT_W'($urandom_range(0, 1023)), LIMIT_W'($urandom_range(0, 1023)));
        random_burst(100, SMP_UNIFORM, 0, 0, 1'b0, -1);

        // Drain, then watch a while longer for stray results
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fault_count == 0 && pending_averages.size() == 0) begin
            $display("** windowed_average_threshold_alarm: PASSED **");
        end else begin
            $display("** windowed_average_threshold_alarm: FAILED **");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run
    initial begin : watchdog
        #5000000;
        $display("** windowed_average_threshold_alarm: FAILED **");
        $finish;
    end

endmodule
